[src/utf8_stream_validator_macros.svh]
// Assertion macros used by the validator back end (u8v_back).
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS
`define U8V_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define U8V_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define U8V_ASSERT(lbl, clk, rst_n, prop, msg)
`define U8V_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[src/u8v_pkg.sv]
package u8v_pkg;

  typedef enum logic [2:0] {
    KIND_NUL,
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_BAD
  } byte_kind_e;

  typedef struct packed {
    logic [7:0] raw;
    logic       is_cont;
    byte_kind_e kind;
    logic       last;
  } item_t;

  localparam logic [20:0] CP_MIN3 = 21'h000800;
  localparam logic [20:0] CP_MIN4 = 21'h010000;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;

endpackage

[src/u8v_front.sv]
module u8v_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     text_byte_i,
  input  logic           last_byte_i,
  output logic           item_valid_o,
  output u8v_pkg::item_t item_o,
  input  logic           item_take_i
);
  import u8v_pkg::*;

  item_t      mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       push_ok;
  item_t      new_item;

  function automatic byte_kind_e classify(input logic [7:0] b);
    byte_kind_e k;
    case (b) inside
      8'h00:          k = KIND_NUL;
      [8'h01:8'h7F]:  k = KIND_ASCII;
      [8'hC0:8'hDF]:  k = KIND_LEAD2;
      [8'hE0:8'hEF]:  k = KIND_LEAD3;
      [8'hF0:8'hF7]:  k = KIND_LEAD4;
      default:        k = KIND_BAD;
    endcase
    return k;
  endfunction

  assign full         = (cnt_q == 2'd2);
  assign push_ok      = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = mem_q[rd_q];

  always_comb begin
    new_item.raw     = text_byte_i;
    new_item.is_cont = (text_byte_i[7:6] == 2'b10);
    new_item.kind    = classify(text_byte_i);
    new_item.last    = last_byte_i;
  end

  always_comb begin
    case ({push_ok, item_take_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wr_q <= ~wr_q;
      end
      if (item_take_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= new_item;
    end
  end

endmodule

[src/u8v_back.sv]
`include "utf8_stream_validator_macros.svh"

module u8v_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  u8v_pkg::item_t item_i,
  output logic           item_take_o,
  output logic           empty,
  input  logic           pop,
  output logic           string_valid_o
);
  import u8v_pkg::*;

  logic [1:0]  pend_q, pend_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] acc_q, acc_d;
  logic        err_q, err_d;
  logic [20:0] cp_next;
  logic [1:0]  pend_dec;
  logic        bad_cp;
  logic        verdict;

  logic        res_q [2];
  logic [1:0]  res_cnt_q, res_cnt_d;
  logic        res_wr_q, res_rd_q;
  logic        res_push, pop_ok;
  logic        res_full;

  assign res_full    = (res_cnt_q == 2'd2);
  assign item_take_o = item_valid_i && (!item_i.last || !res_full);
  assign res_push    = item_take_o && item_i.last;
  assign pop_ok      = pop && !empty;
  assign empty       = (res_cnt_q == 2'd0);
  assign string_valid_o = res_q[res_rd_q];

  assign cp_next  = {acc_q[14:0], item_i.raw[5:0]};
  assign pend_dec = pend_q - 2'd1;
  assign bad_cp   = ((len_q == 3'd3) && (cp_next < CP_MIN4 ? cp_next < CP_MIN3 : 1'b0)) ||
                    ((len_q == 3'd4) && (cp_next < CP_MIN4)) ||
                    ((cp_next >= SURR_LO) && (cp_next <= SURR_HI)) ||
                    (cp_next > CP_MAX);

  always_comb begin
    pend_d  = pend_q;
    len_d   = len_q;
    acc_d   = acc_q;
    err_d   = err_q;
    verdict = 1'b0;
    if (pend_q != 2'd0) begin
      if (!item_i.is_cont) begin
        err_d  = 1'b1;
        pend_d = 2'd0;
        len_d  = 3'd0;
      end else begin
        acc_d  = cp_next;
        pend_d = pend_dec;
        if ((pend_dec == 2'd0) && bad_cp) begin
          err_d = 1'b1;
        end
      end
    end else begin
      case (item_i.kind)
        KIND_NUL: begin
          err_d = 1'b1;
          len_d = 3'd0;
        end
        KIND_ASCII: begin
          len_d  = 3'd1;
          acc_d  = {14'd0, item_i.raw[6:0]};
          pend_d = 2'd0;
        end
        KIND_LEAD2: begin
          len_d  = 3'd2;
          acc_d  = {16'd0, item_i.raw[4:0]};
          pend_d = 2'd1;
          if (item_i.raw[4:1] == 4'd0) begin
            err_d = 1'b1;
          end
        end
        KIND_LEAD3: begin
          len_d  = 3'd3;
          acc_d  = {17'd0, item_i.raw[3:0]};
          pend_d = 2'd2;
        end
        KIND_LEAD4: begin
          len_d  = 3'd4;
          acc_d  = {18'd0, item_i.raw[2:0]};
          pend_d = 2'd3;
        end
        default: begin
          err_d  = 1'b1;
          len_d  = 3'd0;
          pend_d = 2'd0;
        end
      endcase
    end
    if (item_i.last) begin
      verdict = !err_d && (pend_d == 2'd0);
      pend_d  = 2'd0;
      len_d   = 3'd0;
      acc_d   = 21'd0;
      err_d   = 1'b0;
    end
  end

  always_comb begin
    case ({res_push, pop_ok})
      2'b10:   res_cnt_d = res_cnt_q + 2'd1;
      2'b01:   res_cnt_d = res_cnt_q - 2'd1;
      default: res_cnt_d = res_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 2'd0;
      len_q     <= 3'd0;
      acc_q     <= 21'd0;
      err_q     <= 1'b0;
      res_cnt_q <= 2'd0;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
    end else begin
      if (item_take_o) begin
        pend_q <= pend_d;
        len_q  <= len_d;
        acc_q  <= acc_d;
        err_q  <= err_d;
      end
      res_cnt_q <= res_cnt_d;
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (pop_ok) begin
        res_rd_q <= ~res_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= verdict;
    end
  end

  `U8V_ASSERT_NEVER(a_res_cnt_range, clk_i, rst_ni, res_cnt_q == 2'd3, "result queue overflow")
  `U8V_ASSERT(a_clear, clk_i, rst_ni, res_push |=> ({pend_q, len_q, err_q} == '0), "not cleared")
  `U8V_ASSERT(a_pend_len, clk_i, rst_ni, |pend_q |-> ({1'b0, pend_q} < len_q), "bad pending")
  `U8V_ASSERT(a_full_hold, clk_i, rst_ni, res_full && !pop_ok |=> res_full, "result lost")

endmodule

[src/utf8_stream_validator.sv]
// Throughput: one byte per cycle sustained while the result queue has room
// for a last byte's verdict; a two-entry byte queue and a two-entry result
// queue let input and output stall independently.
// Reset (rst_ni low, asynchronous): both queues empty and the decoder state
// cleared, so the next byte starts a new string.
module utf8_stream_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       string_valid_o
);
  import u8v_pkg::*;

  logic  item_valid;
  logic  item_take;
  item_t item;

  u8v_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .text_byte_i  (text_byte_i),
    .last_byte_i  (last_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  u8v_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_take_o    (item_take),
    .empty          (empty),
    .pop            (pop),
    .string_valid_o (string_valid_o)
  );

endmodule
